@@ src/lcsl_pkg.sv @@
// ----------------------------------------------------------------------------
// lcsl_pkg
// Shared types and constants for the LED cube serial loader and scanner.
// ----------------------------------------------------------------------------
package lcsl_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 3;
  localparam int MASK_W = 8;

  // operation codes
  localparam logic OP_SERIAL = 1'b0;
  localparam logic OP_SCAN   = 1'b1;

  // deframer bytes
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'hff;
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h00;

  typedef struct packed {
    logic byte_accept;
    logic read_issue;
    logic stage_move;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_last;
  } dp_status_t;

endpackage

@@ src/lcsl_ram.sv @@
// ----------------------------------------------------------------------------
// lcsl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lcsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/lcsl_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcsl_ctrl
// Controller: input and output handshakes, scan sequencing, pipeline valids.
// ----------------------------------------------------------------------------
module lcsl_ctrl import lcsl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       operation,
  input  logic       out_stall,
  input  dp_status_t status,
  output logic       in_stall,
  output logic       out_valid,
  output ctrl_cmd_t  cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       a_valid;
  logic       a_valid_next;
  logic       b_valid;
  logic       b_valid_next;
  logic       b_free;
  logic       accept;

  always_comb begin
    in_stall       = (state != ST_IDLE);
    out_valid      = b_valid;
    accept         = in_valid && (state == ST_IDLE);
    b_free         = !b_valid || !out_stall;
    cmd.stage_move = a_valid && b_free;
    cmd.read_issue = (state == ST_SCAN) && (!a_valid || cmd.stage_move);
    cmd.byte_accept = accept && (operation == OP_SERIAL);

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (operation == OP_SCAN)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmd.read_issue && status.row_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cmd.read_issue) begin
      a_valid_next = 1'b1;
    end else if (cmd.stage_move) begin
      a_valid_next = 1'b0;
    end else begin
      a_valid_next = a_valid;
    end

    if (cmd.stage_move) begin
      b_valid_next = 1'b1;
    end else if (!out_stall) begin
      b_valid_next = 1'b0;
    end else begin
      b_valid_next = b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      state   <= state_next;
      a_valid <= a_valid_next;
      b_valid <= b_valid_next;
    end
  end

endmodule

@@ src/lcsl_datapath.sv @@
// ----------------------------------------------------------------------------
// lcsl_datapath
// Datapath: escape deframer, load counters, two-bank frame RAM, scan counters
// and the two-stage output pipeline.
// ----------------------------------------------------------------------------
module lcsl_datapath import lcsl_pkg::*; #(
  parameter int CUBE_SIZE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] byte_value,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  output logic [IDX_W-1:0]  latch_index,
  output logic [BYTE_W-1:0] latch_data,
  output logic [MASK_W-1:0] layer_mask,
  output logic              last
);

  localparam int LW    = $clog2(CUBE_SIZE);
  localparam int AW    = 2 * LW + 1;
  localparam int DEPTH = 1 << AW;
  localparam logic [LW-1:0] POS_MAX = LW'(CUBE_SIZE - 1);

  logic              escape;
  logic [LW-1:0]     load_layer;
  logic [LW-1:0]     load_row;
  logic              bank;
  logic              frame_valid;
  logic [LW-1:0]     scan_layer;
  logic [LW-1:0]     scan_row;

  logic              store;
  logic              sync_hit;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] rdata;
  logic [LW+2:0]     row_wide;

  // read stage
  logic [IDX_W-1:0]  a_index;
  logic              a_last;
  logic [MASK_W-1:0] a_mask;
  logic              a_blank;

  always_comb begin
    sync_hit = cmd.byte_accept && escape && (byte_value == SYNC_BYTE);
    if (escape) begin
      store = cmd.byte_accept && (byte_value != SYNC_BYTE);
    end else begin
      store = cmd.byte_accept && (byte_value != ESC_BYTE);
    end
    waddr           = {~bank, load_layer, load_row};
    raddr           = {bank, scan_layer, scan_row};
    row_wide        = (LW + 3)'(scan_row);
    status.row_last = (scan_row == POS_MAX);
  end

  lcsl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (store),
    .waddr (waddr),
    .wdata (byte_value),
    .re    (cmd.read_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      escape      <= 1'b0;
      load_layer  <= '0;
      load_row    <= '0;
      bank        <= 1'b0;
      frame_valid <= 1'b0;
      scan_layer  <= '0;
      scan_row    <= '0;
    end else begin
      if (cmd.byte_accept) begin
        escape <= !escape && (byte_value == ESC_BYTE);
      end
      if (sync_hit) begin
        load_layer <= '0;
        load_row   <= '0;
      end else if (store) begin
        if (load_row == POS_MAX) begin
          load_row <= '0;
          if (load_layer == POS_MAX) begin
            // full frame landed: swap banks
            load_layer  <= '0;
            bank        <= ~bank;
            frame_valid <= 1'b1;
          end else begin
            load_layer <= load_layer + 1'b1;
          end
        end else begin
          load_row <= load_row + 1'b1;
        end
      end
      if (cmd.read_issue) begin
        if (status.row_last) begin
          scan_row <= '0;
          if (scan_layer == POS_MAX) begin
            scan_layer <= '0;
          end else begin
            scan_layer <= scan_layer + 1'b1;
          end
        end else begin
          scan_row <= scan_row + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      a_index <= row_wide[IDX_W-1:0];
      a_last  <= status.row_last;
      a_mask  <= MASK_W'(1) << scan_layer;
      a_blank <= !frame_valid;
    end
    if (cmd.stage_move) begin
      latch_index <= a_index;
      latch_data  <= a_blank ? '0 : rdata;
      layer_mask  <= a_mask;
      last        <= a_last;
    end
  end

endmodule

@@ src/led_cube_serial_loader_scanner_core.sv @@
// ----------------------------------------------------------------------------
// led_cube_serial_loader_scanner_core
// LED cube serial frame loader with escape deframing and layer scan output.
// ----------------------------------------------------------------------------
// A serial byte word produces no output: 0xff opens an escape, escape then
// 0x00 restarts the load position, any other byte is written into the load
// bank of a two-bank frame RAM. When the last byte of a CUBE_SIZE x
// CUBE_SIZE frame lands the banks swap, so the new frame becomes the display
// frame at once; until the first swap the display reads as zeros. A scan tick
// word produces CUBE_SIZE output words, one per row latch, read from the
// display bank at one RAM read per cycle while the output does not stall;
// the input stalls while the reads issue, and the first word passes the scan
// state, the RAM read and read stage, then the output stage. Output stall
// back-pressures the read pipeline and stretches the input stall to match,
// and the next word may be taken while earlier results drain.
// ----------------------------------------------------------------------------
module led_cube_serial_loader_scanner_core import lcsl_pkg::*; #(
  parameter int CUBE_SIZE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [BYTE_W-1:0] byte_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  latch_index,
  output logic [BYTE_W-1:0] latch_data,
  output logic [MASK_W-1:0] layer_mask,
  output logic              last
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lcsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lcsl_datapath #(
    .CUBE_SIZE (CUBE_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .byte_value  (byte_value),
    .cmd         (cmd),
    .status      (status),
    .latch_index (latch_index),
    .latch_data  (latch_data),
    .layer_mask  (layer_mask),
    .last        (last)
  );

`ifndef SYNTH
  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (operation == OP_SCAN) |=> in_stall)
    else $error("scan tick did not hold off the input");

  a_byte_not_during_scan: assert property (@(posedge clk) disable iff (rst)
    !(cmd.byte_accept && cmd.read_issue))
    else $error("serial byte taken while scan reads issue");

  a_rows_back_to_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside a scan burst");
`endif

endmodule

@@ tb/led_cube_scan_checker.sv @@
// ----------------------------------------------------------------------------
// led_cube_scan_checker
// Watches both channels of the LED cube loader and scanner, keeps its own copy
// of the deframer, the load position, the load bank, the shown frame and the
// scan layer, and compares every latch word against the words it predicts.
// ----------------------------------------------------------------------------
module led_cube_scan_checker import lcsl_pkg::*; #(
  parameter int CUBE_SIZE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              operation,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [IDX_W-1:0]  latch_index,
  input  logic [BYTE_W-1:0] latch_data,
  input  logic [MASK_W-1:0] layer_mask,
  input  logic              last,
  output int                fails,
  output int                words_due,
  output int                words_checked,
  output int                frames_loaded
);

  localparam int FRAME_BYTES = CUBE_SIZE * CUBE_SIZE;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] data;
    logic [MASK_W-1:0] mask;
    logic              last;
  } latch_word_t;

  latch_word_t       due_latch_words[$];
  logic              esc_open;
  int                fill_layer;
  int                fill_row;
  int                scan_layer;
  logic [BYTE_W-1:0] fill_bank[FRAME_BYTES];
  logic [BYTE_W-1:0] shown_frame[FRAME_BYTES];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("latch word %0d: %s got 0x%0h want 0x%0h", words_checked, what, got, want);
    fails++;
  endtask

  task automatic store_cube_byte(input logic [BYTE_W-1:0] b);
    fill_bank[fill_layer * CUBE_SIZE + fill_row] = b;
    if (fill_row == CUBE_SIZE - 1) begin
      fill_row = 0;
      if (fill_layer == CUBE_SIZE - 1) begin
        fill_layer = 0;
        for (int i = 0; i < FRAME_BYTES; i++) shown_frame[i] = fill_bank[i];
        frames_loaded++;
      end else begin
        fill_layer++;
      end
    end else begin
      fill_row++;
    end
  endtask

  task automatic take_word(input logic op, input logic [BYTE_W-1:0] b);
    latch_word_t w;
    if (op == OP_SERIAL) begin
      if (esc_open) begin
        esc_open = 1'b0;
        if (b == SYNC_BYTE) begin
          fill_layer = 0;
          fill_row = 0;
        end else begin
          store_cube_byte(b);
        end
      end else if (b == ESC_BYTE) begin
        esc_open = 1'b1;
      end else begin
        store_cube_byte(b);
      end
    end else begin
      for (int r = 0; r < CUBE_SIZE; r++) begin
        w.index = r[IDX_W-1:0];
        w.data = shown_frame[scan_layer * CUBE_SIZE + r];
        w.mask = '0;
        w.mask[scan_layer] = 1'b1;
        w.last = (r == CUBE_SIZE - 1);
        due_latch_words.push_back(w);
      end
      scan_layer = (scan_layer + 1) % CUBE_SIZE;
    end
  endtask

  task automatic check_latch_word();
    latch_word_t want;
    if (due_latch_words.size() == 0) begin
      report_mismatch("unexpected word, data", latch_data, 0);
    end else begin
      want = due_latch_words.pop_front();
      if (latch_index !== want.index) report_mismatch("latch_index", latch_index, want.index);
      if (latch_data !== want.data) report_mismatch("latch_data", latch_data, want.data);
      if (layer_mask !== want.mask) report_mismatch("layer_mask", layer_mask, want.mask);
      if (last !== want.last) report_mismatch("last", last, want.last);
    end
    words_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      esc_open = 1'b0;
      fill_layer = 0;
      fill_row = 0;
      scan_layer = 0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        fill_bank[i] = '0;
        shown_frame[i] = '0;
      end
      due_latch_words.delete();
      fails = 0;
      words_checked = 0;
      frames_loaded = 0;
    end else begin
      if (in_valid && !in_stall) take_word(operation, byte_value);
      if (out_valid && !out_stall) check_latch_word();
    end
    words_due = due_latch_words.size();
  end

endmodule

@@ tb/led_cube_serial_loader_scanner_core_test.sv @@
// ----------------------------------------------------------------------------
// led_cube_serial_loader_scanner_core_test
// Drives serial bytes and scan ticks into the LED cube loader and scanner:
// a directed opening on the escape and sync cases, then escaped frames with
// random content, broken frames and raw noise, under three idling phases.
// ----------------------------------------------------------------------------
module led_cube_serial_loader_scanner_core_test;
  import lcsl_pkg::*;

  localparam int CUBE_SIZE    = 8;
  localparam int RANDOM_WORDS = 345;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_A_END  = 145;
  localparam int PHASE_B_END  = 290;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              operation = OP_SERIAL;
  logic [BYTE_W-1:0] byte_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  latch_index;
  logic [BYTE_W-1:0] latch_data;
  logic [MASK_W-1:0] layer_mask;
  logic              last;

  int fails;
  int words_due;
  int words_checked;
  int frames_loaded;
  int sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #1 clk = ~clk;

  led_cube_serial_loader_scanner_core #(.CUBE_SIZE(CUBE_SIZE)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .byte_value(byte_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .latch_index(latch_index), .latch_data(latch_data),
    .layer_mask(layer_mask), .last(last)
  );

  led_cube_scan_checker #(.CUBE_SIZE(CUBE_SIZE)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .byte_value(byte_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .latch_index(latch_index), .latch_data(latch_data),
    .layer_mask(layer_mask), .last(last),
    .fails(fails), .words_due(words_due),
    .words_checked(words_checked), .frames_loaded(frames_loaded)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d latch words due", cycles, words_due);
      $display("led_cube_serial_loader_scanner_core_test: FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic op, input logic [BYTE_W-1:0] b);
    if (sent < PHASE_A_END) begin
      send_idle_pct = 12;
      recv_stall_pct = 87;
    end else if (sent < PHASE_B_END) begin
      send_idle_pct = 87;
      recv_stall_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_tick();
    send_word(OP_SCAN, BYTE_W'($urandom_range(0, 255)));
  endtask

  // 0xff as data goes out escaped
  task automatic send_data(input logic [BYTE_W-1:0] b);
    if (b == ESC_BYTE) send_word(OP_SERIAL, ESC_BYTE);
    send_word(OP_SERIAL, b);
  endtask

  task automatic send_sync();
    send_word(OP_SERIAL, ESC_BYTE);
    send_word(OP_SERIAL, SYNC_BYTE);
  endtask

  function automatic logic [BYTE_W-1:0] cube_byte(input int mode);
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    case (mode)
      1: b = ESC_BYTE;
      2: b = SYNC_BYTE;
      default: begin
        if ($urandom_range(0, 5) == 0) begin
          case ($urandom_range(0, 3))
            0: b = ESC_BYTE;
            1: b = SYNC_BYTE;
            2: b = 8'h01;
            default: b = 8'h80;
          endcase
        end
      end
    endcase
    return b;
  endfunction

  task automatic send_frame();
    int mode;
    mode = ($urandom_range(0, 5) < 4) ? 0 : $urandom_range(1, 2);
    if ($urandom_range(0, 3) != 0) send_sync();
    for (int i = 0; i < CUBE_SIZE * CUBE_SIZE; i++) begin
      if ($urandom_range(0, 5) == 0) send_tick();
      send_data(cube_byte(mode));
    end
    repeat ($urandom_range(1, CUBE_SIZE)) send_tick();
  endtask

  // partial frame, sometimes left with an escape open across a tick
  task automatic send_broken_frame();
    send_sync();
    repeat ($urandom_range(1, CUBE_SIZE * CUBE_SIZE - 1)) send_data(cube_byte(0));
    if ($urandom_range(0, 1) == 0) begin
      send_word(OP_SERIAL, ESC_BYTE);
      send_tick();
      send_word(OP_SERIAL, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int stop_at;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // blank display, plain data, sync, escaped 0xff, escape across a tick
    send_tick();
    send_word(OP_SERIAL, 8'h00);
    send_word(OP_SERIAL, 8'h7f);
    send_word(OP_SERIAL, 8'h80);
    send_sync();
    send_word(OP_SERIAL, ESC_BYTE);
    send_word(OP_SERIAL, ESC_BYTE);
    send_word(OP_SERIAL, ESC_BYTE);
    send_word(OP_SERIAL, 8'h01);
    send_word(OP_SERIAL, 8'hfe);
    send_word(OP_SERIAL, ESC_BYTE);
    send_tick();
    send_word(OP_SERIAL, SYNC_BYTE);
    repeat (CUBE_SIZE - 1) send_tick();

    stop_at = sent + RANDOM_WORDS;
    while (sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_frame();
        5, 6: repeat ($urandom_range(1, 10)) send_tick();
        7: send_broken_frame();
        default: begin
          repeat ($urandom_range(1, 12))
            send_word(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
        end
      endcase
    end

    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("%0d words sent, %0d frames loaded and shown, %0d latch words checked",
             sent, frames_loaded, words_checked);
    $display("covered escapes, syncs, broken frames and all layers under three idling phases");
    if (fails == 0) begin
      $display("led_cube_serial_loader_scanner_core_test: PASS");
    end else begin
      $display("led_cube_serial_loader_scanner_core_test: FAIL");
    end
    $finish;
  end

endmodule
